// ===== hdl/lmss_pkg.sv =====
// types and constants of the led matrix scroll scanner
// no dependencies; imported by led_matrix_scroll_scanner_unit
package lmss_pkg;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;
    localparam logic [1:0] OP_STOP  = 2'd3;

    localparam logic [1:0] REG_TICKS_PER_COLUMN = 2'd0;
    localparam logic [1:0] REG_FRAMES_PER_STEP  = 2'd1;
    localparam logic [1:0] REG_PATTERN_LENGTH   = 2'd2;

    localparam logic [15:0] TICKS_PER_COLUMN_RST = 16'd1000;
    localparam logic [15:0] FRAMES_PER_STEP_RST  = 16'd10;
    localparam logic [8:0]  PATTERN_LENGTH_RST   = 9'd8;

    localparam logic [7:0] COLUMNS_OFF = 8'hFF;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] address;
        logic [7:0] value;
    } in_word_t;

    typedef struct packed {
        logic [7:0] row_drive;
        logic [7:0] column_enable_n;
        logic       busy_res;
        logic       done_res;
    } out_word_t;

    typedef struct packed {
        logic       show;
        logic       fwd;
        logic [7:0] fwd_value;
        logic [7:0] column_enable_n;
        logic       busy;
        logic       done;
    } side_t;

endpackage

// ===== hdl/led_matrix_scroll_scanner_unit.sv =====
// Column-multiplexed LED matrix scroller. Takes one word per clock cycle on
// s_ while s_ready is high and returns one result word per input word on m_.
// The counters live in registers; the pattern store is a synchronous
// single-port-write memory read once per word, with a pattern write forwarded
// to its own result when it hits the address read. A two-entry output path
// (read stage and output register) keeps input flowing while one result
// waits. Configuration is written through the APB port at 4*index.
// depends on lmss_pkg
module led_matrix_scroll_scanner_unit
    import lmss_pkg::*;
#(
    parameter int PATTERN_DEPTH  = 256,
    parameter int MATRIX_COLUMNS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_word_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_word_t   m_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(PATTERN_DEPTH);
    localparam int OW = AW + 1;
    localparam int CW = $clog2(MATRIX_COLUMNS);
    localparam int EW = (OW > 9) ? OW : 9;
    localparam int SW = AW + 2;

    // configuration
    logic [15:0] tpc_reg;
    logic [15:0] fps_reg;
    logic [8:0]  len_reg;
    logic        cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tpc_reg <= TICKS_PER_COLUMN_RST;
            fps_reg <= FRAMES_PER_STEP_RST;
            len_reg <= PATTERN_LENGTH_RST;
        end else if (cfg_we) begin
            case (paddr[3:2])
                REG_TICKS_PER_COLUMN: tpc_reg <= pwdata[15:0];
                REG_FRAMES_PER_STEP:  fps_reg <= pwdata[15:0];
                REG_PATTERN_LENGTH:   len_reg <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_TICKS_PER_COLUMN: prdata = {16'd0, tpc_reg};
            REG_FRAMES_PER_STEP:  prdata = {16'd0, fps_reg};
            REG_PATTERN_LENGTH:   prdata = {23'd0, len_reg};
            default:              prdata = 32'd0;
        endcase
    end

    // scan state
    logic [OW-1:0] offset_reg, offset_next;
    logic [CW-1:0] col_reg, col_next;
    logic [15:0]   dwell_reg, dwell_next;
    logic [15:0]   frame_reg, frame_next;
    logic          running_reg, running_next;

    // pipeline
    logic      p1_valid_reg;
    side_t     p1_side_reg, side_next;
    logic [7:0] rd_data_reg;
    logic      out_valid_reg;
    out_word_t out_reg;
    logic      accept, p1_adv, out_load;

    assign out_load = p1_valid_reg && (!out_valid_reg || m_ready);
    assign p1_adv   = out_load;
    assign s_ready  = !p1_valid_reg || p1_adv;
    assign accept   = s_valid && s_ready;

    logic [EW-1:0] eff_len;
    logic [EW:0]   end_sum;
    logic          run_end;
    logic [SW-1:0] idx_sum;
    logic [AW-1:0] raddr;
    logic [AW-1:0] waddr;
    logic          write_ok;
    logic [7:0]    col_sel;
    logic [15:0]   dwell_inc;
    logic [15:0]   frame_inc;

    always_comb begin
        if (EW'(len_reg) > EW'(PATTERN_DEPTH)) begin
            eff_len = EW'(PATTERN_DEPTH);
        end else begin
            eff_len = EW'(len_reg);
        end
        end_sum = (EW + 1)'(offset_reg) + (EW + 1)'(MATRIX_COLUMNS);
        run_end = end_sum > (EW + 1)'(eff_len);

        idx_sum = SW'(offset_reg) + SW'(col_reg);
        if (idx_sum >= SW'(PATTERN_DEPTH)) begin
            idx_sum = idx_sum - SW'(PATTERN_DEPTH);
        end
        raddr = idx_sum[AW-1:0];

        waddr    = AW'(s_data.address);
        write_ok = (int'(s_data.address) < PATTERN_DEPTH);

        col_sel = 8'd0;
        if (int'(col_reg) < 8) begin
            col_sel = 8'd1 << col_reg;
        end
        dwell_inc = dwell_reg + 16'd1;
        frame_inc = frame_reg + 16'd1;
    end

    always_comb begin
        offset_next  = offset_reg;
        col_next     = col_reg;
        dwell_next   = dwell_reg;
        frame_next   = frame_reg;
        running_next = running_reg;
        side_next.show            = 1'b0;
        side_next.fwd             = 1'b0;
        side_next.fwd_value       = s_data.value;
        side_next.column_enable_n = COLUMNS_OFF;
        side_next.busy            = 1'b0;
        side_next.done            = 1'b0;
        case (s_data.opcode)
            OP_WRITE: begin
                side_next.fwd = write_ok && (waddr == raddr);
                if (running_reg) begin
                    side_next.show            = 1'b1;
                    side_next.column_enable_n = ~col_sel;
                    side_next.busy            = 1'b1;
                end
            end
            OP_START: begin
                offset_next = '0;
                col_next    = '0;
                dwell_next  = '0;
                frame_next  = '0;
                if (eff_len < EW'(MATRIX_COLUMNS)) begin
                    running_next   = 1'b0;
                    side_next.done = 1'b1;
                end else begin
                    running_next   = 1'b1;
                    side_next.busy = 1'b1;
                end
            end
            OP_STOP: begin
                running_next = 1'b0;
            end
            default: begin
                if (running_reg) begin
                    if (run_end) begin
                        running_next   = 1'b0;
                        side_next.done = 1'b1;
                    end else begin
                        side_next.show            = 1'b1;
                        side_next.column_enable_n = ~col_sel;
                        side_next.busy            = 1'b1;
                        dwell_next = dwell_inc;
                        if (dwell_inc == tpc_reg) begin
                            dwell_next = '0;
                            if (col_reg == CW'(MATRIX_COLUMNS - 1)) begin
                                col_next   = '0;
                                frame_next = frame_inc;
                                if (frame_inc == fps_reg) begin
                                    frame_next  = '0;
                                    offset_next = offset_reg + OW'(1);
                                end
                            end else begin
                                col_next = col_reg + CW'(1);
                            end
                        end
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg  <= '0;
            col_reg     <= '0;
            dwell_reg   <= '0;
            frame_reg   <= '0;
            running_reg <= 1'b0;
        end else if (accept) begin
            offset_reg  <= offset_next;
            col_reg     <= col_next;
            dwell_reg   <= dwell_next;
            frame_reg   <= frame_next;
            running_reg <= running_next;
        end
    end

    // pattern store, read before write on the same edge
    logic [7:0] mem [PATTERN_DEPTH];

    always_ff @(posedge aclk) begin
        if (accept) begin
            if (s_data.opcode == OP_WRITE && write_ok) begin
                mem[waddr] <= s_data.value;
            end
            rd_data_reg <= mem[raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (accept) begin
            p1_valid_reg <= 1'b1;
        end else if (p1_adv) begin
            p1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_side_reg <= side_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            if (!p1_side_reg.show) begin
                out_reg.row_drive <= 8'd0;
            end else if (p1_side_reg.fwd) begin
                out_reg.row_drive <= p1_side_reg.fwd_value;
            end else begin
                out_reg.row_drive <= rd_data_reg;
            end
            out_reg.column_enable_n <= p1_side_reg.column_enable_n;
            out_reg.busy_res        <= p1_side_reg.busy;
            out_reg.done_res        <= p1_side_reg.done;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.busy_res && m_data.done_res))
        else $error("busy and done together");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.busy_res) |->
            (m_data.column_enable_n == COLUMNS_OFF && m_data.row_drive == 8'd0))
        else $error("display lit while not busy");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (p1_valid_reg && out_valid_reg && !m_ready))
        else $error("input stalled with room in the output path");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (p1_valid_reg && !p1_adv) |=> (p1_valid_reg && $stable(rd_data_reg)))
        else $error("read stage lost its word while stalled");

endmodule
